FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/psts_pkg.sv
// ----------------------------------------------------------------------------
// Pot soft-takeover scaler package
// Constants, widths and result codes shared by the scaler core.
// ----------------------------------------------------------------------------
`default_nettype none

package psts_pkg;

    localparam int NUM_POTS_DEF = 3;
    localparam int POS_W        = 17;
    localparam int VAL_W        = 32;
    localparam int SNAP_INPUTS  = 3;

    localparam logic [POS_W-1:0] JUMP_MIN    = 17'd656;
    localparam logic [POS_W-1:0] SNAP_HIGH   = 17'd65209;
    localparam logic [POS_W-1:0] SNAP_LOW    = 17'd327;
    localparam logic [POS_W:0]   FULL_TRAVEL = 18'd65536;

    // Dividend is |value range| (32 bits) times |dx| (10 bits).
    localparam int DXM_W = 10;
    localparam int QUO_W = VAL_W + DXM_W;

    typedef enum logic [2:0] {
        OUT_NOT_PRIMED = 3'd0,
        OUT_JUMP       = 3'd1,
        OUT_SNAP_MAX   = 3'd2,
        OUT_SNAP_MIN   = 3'd3,
        OUT_SCALED     = 3'd4,
        OUT_RECORDED   = 3'd5
    } outcome_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pot_soft_takeover_scaler_core.sv
// ----------------------------------------------------------------------------
// Pot soft-takeover scaler core
// Moves a parameter value in step with a pot, scaled to the travel left.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one item: either a
// record of all pot positions, which primes the block, or an update from one
// pot together with the current value and its limits. Each item yields one
// result item (value_out, outcome) on the output channel (out_valid,
// out_stall). Records, ignored moves, snaps and scaled moves with a zero pot
// range pass from acceptance through the classification to the load of the
// output register. A scaled move passes through the classification, the 32
// by 10 bit multiply, the restoring divider that produces one quotient bit a
// cycle, the final add with saturation and the load of the output register.
// in_stall is high from acceptance until the result is loaded into the
// output register, so a new item is taken only after that load: the block
// works on one item at a time. A new item may be taken while an earlier
// result still waits. If the receiver stalls, the result is held and a
// finished item waits until the output register is free. Reset clears the
// stored positions, the primed flag and all control state; the block is then
// idle and ready to accept an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pot_soft_takeover_scaler_core #(
    parameter int NUM_POTS = psts_pkg::NUM_POTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [1:0]                          pot_index,
    input  logic [psts_pkg::POS_W-1:0]          pot_position,
    input  logic [psts_pkg::POS_W-1:0]          snap_pot_zero,
    input  logic [psts_pkg::POS_W-1:0]          snap_pot_one,
    input  logic [psts_pkg::POS_W-1:0]          snap_pot_two,
    input  logic signed [psts_pkg::VAL_W-1:0]   value_in,
    input  logic signed [psts_pkg::VAL_W-1:0]   value_min,
    input  logic signed [psts_pkg::VAL_W-1:0]   value_max,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [psts_pkg::VAL_W-1:0]   value_out,
    output logic [2:0]                          outcome
);

    localparam int POS_W = psts_pkg::POS_W;
    localparam int VAL_W = psts_pkg::VAL_W;
    localparam int QUO_W = psts_pkg::QUO_W;
    localparam int DXM_W = psts_pkg::DXM_W;
    localparam int IW    = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;
    localparam int CNT_W = $clog2(QUO_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [POS_W-1:0]           prev_reg [NUM_POTS];
    logic                       primed_reg;
    logic                       kind_reg;
    logic [1:0]                 pot_index_reg;
    logic [POS_W-1:0]           pos_reg;
    logic signed [VAL_W-1:0]    val_reg;
    logic signed [VAL_W-1:0]    vmin_reg;
    logic signed [VAL_W-1:0]    vmax_reg;
    logic [VAL_W-1:0]           vmag_reg;
    logic [DXM_W-1:0]           dxmag_reg;
    logic [POS_W-1:0]           div_reg;
    logic                       neg_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic [POS_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [VAL_W-1:0]    result_reg;
    psts_pkg::outcome_t         outcome_reg;
    logic                       out_valid_reg;
    logic signed [VAL_W-1:0]    value_out_reg;
    logic [2:0]                 outcome_out_reg;

    logic                       accept;
    logic [POS_W-1:0]           snap_arr [psts_pkg::SNAP_INPUTS];
    logic [IW+1:0]              idx_ext;
    logic                       idx_ok;
    logic [POS_W-1:0]           prev_sel;
    logic signed [POS_W:0]      dx;
    logic [POS_W:0]             adx;
    logic                       inc;
    logic                       jump;
    logic signed [VAL_W:0]      vrange;
    logic [VAL_W:0]             vrange_mag;
    logic signed [POS_W:0]      prange;
    logic [POS_W:0]             prange_mag;
    logic [POS_W+1:0]           trial;
    logic signed [QUO_W:0]      q_signed;
    logic signed [QUO_W+1:0]    sum;
    logic signed [VAL_W-1:0]    sum_sat;
    logic                       out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign snap_arr[0] = snap_pot_zero;
    assign snap_arr[1] = snap_pot_one;
    assign snap_arr[2] = snap_pot_two;

    // Classification of an update against the stored snapshot.
    assign idx_ext    = (IW + 2)'(pot_index_reg);
    assign idx_ok     = (32'(pot_index_reg) < NUM_POTS);
    assign prev_sel   = prev_reg[idx_ext[IW-1:0]];
    assign dx         = $signed({1'b0, pos_reg}) - $signed({1'b0, prev_sel});
    assign adx        = dx[POS_W] ? (POS_W + 1)'(-dx) : dx;
    assign inc        = !dx[POS_W] && (dx != '0);
    assign jump       = (adx >= {1'b0, psts_pkg::JUMP_MIN});
    assign vrange     = inc ? ({vmax_reg[VAL_W-1], vmax_reg} - {val_reg[VAL_W-1], val_reg})
                            : ({val_reg[VAL_W-1], val_reg} - {vmin_reg[VAL_W-1], vmin_reg});
    assign vrange_mag = vrange[VAL_W] ? (VAL_W + 1)'(-vrange) : vrange;
    assign prange     = inc ? $signed(psts_pkg::FULL_TRAVEL - {1'b0, prev_sel})
                            : $signed({1'b0, prev_sel});
    assign prange_mag = prange[POS_W] ? (POS_W + 1)'(-prange) : prange;

    // Restoring divider step: one quotient bit a cycle.
    assign trial    = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, div_reg};

    assign q_signed = neg_reg ? (QUO_W + 1)'(-$signed({1'b0, quo_reg}))
                              : $signed({1'b0, quo_reg});
    assign sum      = (QUO_W + 2)'(val_reg) + (QUO_W + 2)'(q_signed);

    always_comb
    begin
        if (sum > (QUO_W + 2)'(signed'(32'sh7FFF_FFFF)))
        begin
            sum_sat = 32'sh7FFF_FFFF;
        end
        else if (sum < (QUO_W + 2)'(signed'(32'sh8000_0000)))
        begin
            sum_sat = 32'sh8000_0000;
        end
        else
        begin
            sum_sat = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            primed_reg      <= 1'b0;
            for (int i = 0; i < NUM_POTS; i++)
            begin
                prev_reg[i] <= '0;
            end
            kind_reg        <= 1'b0;
            pot_index_reg   <= '0;
            pos_reg         <= '0;
            val_reg         <= '0;
            vmin_reg        <= '0;
            vmax_reg        <= '0;
            vmag_reg        <= '0;
            dxmag_reg       <= '0;
            div_reg         <= '0;
            neg_reg         <= 1'b0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            result_reg      <= '0;
            outcome_reg     <= psts_pkg::OUT_NOT_PRIMED;
            out_valid_reg   <= 1'b0;
            value_out_reg   <= '0;
            outcome_out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg      <= kind;
                        pot_index_reg <= pot_index;
                        pos_reg       <= pot_position;
                        val_reg       <= value_in;
                        vmin_reg      <= value_min;
                        vmax_reg      <= value_max;
                        if (!kind)
                        begin
                            for (int i = 0; i < NUM_POTS; i++)
                            begin
                                prev_reg[i] <= (i < psts_pkg::SNAP_INPUTS)
                                               ? snap_arr[i % psts_pkg::SNAP_INPUTS] : '0;
                            end
                            primed_reg <= 1'b1;
                        end
                        state_reg <= ST_EVAL;
                    end
                end

                ST_EVAL:
                begin
                    result_reg <= val_reg;
                    state_reg  <= ST_OUT;
                    if (!kind_reg)
                    begin
                        outcome_reg <= psts_pkg::OUT_RECORDED;
                    end
                    else if (!primed_reg)
                    begin
                        outcome_reg <= psts_pkg::OUT_NOT_PRIMED;
                    end
                    else if (!idx_ok || jump)
                    begin
                        outcome_reg <= psts_pkg::OUT_JUMP;
                    end
                    else if (inc && (pos_reg >= psts_pkg::SNAP_HIGH))
                    begin
                        result_reg  <= vmax_reg;
                        outcome_reg <= psts_pkg::OUT_SNAP_MAX;
                    end
                    else if (!inc && (pos_reg <= psts_pkg::SNAP_LOW))
                    begin
                        result_reg  <= vmin_reg;
                        outcome_reg <= psts_pkg::OUT_SNAP_MIN;
                    end
                    else
                    begin
                        outcome_reg <= psts_pkg::OUT_SCALED;
                        if (prange != '0)
                        begin
                            vmag_reg  <= vrange_mag[VAL_W-1:0];
                            dxmag_reg <= adx[DXM_W-1:0];
                            div_reg   <= prange_mag[POS_W-1:0];
                            neg_reg   <= vrange[VAL_W] ^ dx[POS_W] ^ prange[POS_W];
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    quo_reg   <= vmag_reg * dxmag_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(QUO_W - 1);
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (trial[POS_W+1])
                    begin
                        rem_reg <= {rem_reg[POS_W-2:0], quo_reg[QUO_W-1]};
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= trial[POS_W-1:0];
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_SUM;
                    end
                end

                ST_SUM:
                begin
                    result_reg <= sum_sat;
                    state_reg  <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        value_out_reg   <= result_reg;
                        outcome_out_reg <= outcome_reg;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign outcome   = outcome_out_reg;

    `ASSERT_NEXT(a_accept_to_eval, clk, rst_n, accept, state_reg == ST_EVAL)
    `ASSERT_IMPLY(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, div_reg != '0)
    `ASSERT_NEXT(a_load_from_out, clk, rst_n, (state_reg == ST_OUT) && out_free, out_valid && (state_reg == ST_IDLE))
    `ASSERT_IMPLY(a_outcome_code, clk, rst_n, out_valid, outcome <= 3'(psts_pkg::OUT_RECORDED))

endmodule

`default_nettype wire
